FILE: rtl/lpcp_pkg.sv
// lpcp_pkg: shared types, widths and constants for the lidar point projection unit
// no dependencies
package lpcp_pkg;

   localparam int MAX_IMAGE_DIM = 4096;
   localparam int DIM_W         = $clog2(MAX_IMAGE_DIM) + 1;
   localparam int PIX_W         = 12;
   localparam int COORD_W       = 24;
   localparam int CAM_W         = 43;   // camera frame coordinate, 2^-24 m
   localparam int SPLIT_W       = 21;   // low half of a camera coordinate
   localparam int PROD_W        = 39;   // 22 x 17 signed partial product
   localparam int NUM_W         = 60;   // projection numerator, signed
   localparam int DEN_W         = 46;   // 16 * depth
   localparam int DIV_CELLS     = DIM_W;   // quotient bits resolved in the chain
   localparam int XFORM_STAGES  = 2;
   localparam int PROJ_STAGES   = 3;
   localparam int LATENCY       = XFORM_STAGES + PROJ_STAGES + DIV_CELLS + 1;

   typedef enum logic [2:0] {
      REG_ROW_X   = 3'd0,
      REG_ROW_Y   = 3'd1,
      REG_ROW_Z   = 3'd2,
      REG_FOCAL   = 3'd3,
      REG_CENTER  = 3'd4,
      REG_WIDTH   = 3'd5,
      REG_HEIGHT  = 3'd6,
      REG_NONE    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } point_type;

   typedef struct packed {
      logic [PIX_W-1:0]          pixel_col;
      logic [PIX_W-1:0]          pixel_row;
      logic                      in_view;
      logic signed [COORD_W-1:0] orig_x;
      logic signed [COORD_W-1:0] orig_y;
      logic signed [COORD_W-1:0] orig_z;
   } result_type;

   typedef struct packed {
      logic                    valid;
      logic signed [CAM_W-1:0] cam_x;
      logic signed [CAM_W-1:0] cam_y;
      logic signed [CAM_W-1:0] cam_z;
      point_type               point;
   } xform_type;

   typedef struct packed {
      logic              valid;
      logic              pos;
      logic              neg_u;
      logic              neg_v;
      logic [NUM_W-1:0]  abs_u;
      logic [NUM_W-1:0]  abs_v;
      logic [DEN_W-1:0]  den;
      point_type         point;
   } proj_type;

   typedef struct packed {
      logic                 valid;
      logic                 pos;
      logic                 neg_u;
      logic                 neg_v;
      logic                 ovf_u;
      logic                 ovf_v;
      logic [NUM_W-1:0]     rem_u;
      logic [NUM_W-1:0]     rem_v;
      logic [DEN_W-1:0]     den;
      logic [DIV_CELLS-1:0] quo_u;
      logic [DIV_CELLS-1:0] quo_v;
      point_type            point;
   } div_type;

endpackage

FILE: rtl/lidar_point_camera_projection_unit.sv
// lidar_point_camera_projection_unit: top level, register file, cell chain, bounds check
// depends on lpcp_pkg, lpcp_transform, lpcp_project, lpcp_div_cell
// throughput: one point per cycle, busy is never raised
// 2 transform stages, 3 numerator stages, 13 division cells, 1 output stage
// the receiver cannot stall, every result is a one-cycle strobe
// reset (synchronous) empties the pipe and loads the register defaults
module lidar_point_camera_projection_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lpcp_pkg::point_type   req_point,
   output logic                  rsp_valid,
   output lpcp_pkg::result_type  rsp_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [5:0]            paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);
   // configuration registers
   logic [63:0] row_x_ff, row_y_ff, row_z_ff;
   logic [31:0] focal_ff, center_ff;
   logic [lpcp_pkg::DIM_W-1:0] width_ff, height_ff;
   lpcp_pkg::reg_index_type reg_sel;
   logic cfg_write;

   lpcp_pkg::xform_type xform;
   lpcp_pkg::proj_type  proj;
   lpcp_pkg::div_type   chain [lpcp_pkg::DIV_CELLS + 1];

   logic                     out_valid_ff;
   lpcp_pkg::result_type     out_ff, out_in;
   logic [lpcp_pkg::DIM_W-1:0] dim_w, dim_h;
   logic                     u_ok, v_ok, view;

   // the block takes a point every cycle
   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign reg_sel   = lpcp_pkg::reg_index_type'(paddr[5:3]);
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= 64'h0000_0000_4000_0000;
         row_y_ff  <= 64'h0000_0000_0000_4000;
         row_z_ff  <= 64'h0;
         focal_ff  <= 32'h0;
         center_ff <= 32'h0;
         width_ff  <= lpcp_pkg::DIM_W'(640);
         height_ff <= lpcp_pkg::DIM_W'(480);
      end else if (cfg_write) begin
         case (reg_sel)
            lpcp_pkg::REG_ROW_X:  row_x_ff  <= pwdata;
            lpcp_pkg::REG_ROW_Y:  row_y_ff  <= pwdata;
            lpcp_pkg::REG_ROW_Z:  row_z_ff  <= pwdata;
            lpcp_pkg::REG_FOCAL:  focal_ff  <= pwdata[31:0];
            lpcp_pkg::REG_CENTER: center_ff <= pwdata[31:0];
            lpcp_pkg::REG_WIDTH:  width_ff  <= pwdata[lpcp_pkg::DIM_W-1:0];
            lpcp_pkg::REG_HEIGHT: height_ff <= pwdata[lpcp_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         lpcp_pkg::REG_ROW_X:  prdata = row_x_ff;
         lpcp_pkg::REG_ROW_Y:  prdata = row_y_ff;
         lpcp_pkg::REG_ROW_Z:  prdata = row_z_ff;
         lpcp_pkg::REG_FOCAL:  prdata = {32'h0, focal_ff};
         lpcp_pkg::REG_CENTER: prdata = {32'h0, center_ff};
         lpcp_pkg::REG_WIDTH:  prdata = 64'(width_ff);
         lpcp_pkg::REG_HEIGHT: prdata = 64'(height_ff);
         default:              prdata = 64'h0;
      endcase
   end

   // rotation and translation into the camera frame
   lpcp_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .src_point (req_point),
      .row_x     (row_x_ff),
      .row_y     (row_y_ff),
      .row_z     (row_z_ff),
      .out_xform (xform)
   );

   // numerators c*f + center*depth and divisor 16*depth
   lpcp_project u_project (
      .clock    (clock),
      .reset    (reset),
      .in_xform (xform),
      .focal_x  (focal_ff[31:16]),
      .focal_y  (focal_ff[15:0]),
      .center_x (center_ff[31:16]),
      .center_y (center_ff[15:0]),
      .out_proj (proj)
   );

   // chain entry: a quotient of 2^13 or more can never land inside the image
   always_comb begin
      chain[0].valid = proj.valid;
      chain[0].pos   = proj.pos;
      chain[0].neg_u = proj.neg_u;
      chain[0].neg_v = proj.neg_v;
      chain[0].ovf_u = (proj.abs_u >=
                        lpcp_pkg::NUM_W'({proj.den, lpcp_pkg::DIV_CELLS'(0)}));
      chain[0].ovf_v = (proj.abs_v >=
                        lpcp_pkg::NUM_W'({proj.den, lpcp_pkg::DIV_CELLS'(0)}));
      chain[0].rem_u = proj.abs_u;
      chain[0].rem_v = proj.abs_v;
      chain[0].den   = proj.den;
      chain[0].quo_u = '0;
      chain[0].quo_v = '0;
      chain[0].point = proj.point;
   end

   // one quotient bit per cell, most significant first
   for (genvar i = 0; i < lpcp_pkg::DIV_CELLS; i++) begin : g_cell
      lpcp_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_div  (chain[i]),
         .out_div (chain[i+1])
      );
   end

   // bounds check; a negative numerator is in view only when it truncates to zero
   always_comb begin
      dim_w = (width_ff > lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM))
            ? lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM) : width_ff;
      dim_h = (height_ff > lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM))
            ? lpcp_pkg::DIM_W'(lpcp_pkg::MAX_IMAGE_DIM) : height_ff;
      u_ok = !chain[lpcp_pkg::DIV_CELLS].ovf_u
          && (chain[lpcp_pkg::DIV_CELLS].neg_u ? chain[lpcp_pkg::DIV_CELLS].quo_u == '0
              : lpcp_pkg::DIM_W'(chain[lpcp_pkg::DIV_CELLS].quo_u) < dim_w);
      v_ok = !chain[lpcp_pkg::DIV_CELLS].ovf_v
          && (chain[lpcp_pkg::DIV_CELLS].neg_v ? chain[lpcp_pkg::DIV_CELLS].quo_v == '0
              : lpcp_pkg::DIM_W'(chain[lpcp_pkg::DIV_CELLS].quo_v) < dim_h);
      view = chain[lpcp_pkg::DIV_CELLS].pos && u_ok && v_ok
          && (dim_w != '0) && (dim_h != '0);
      out_in.in_view   = view;
      out_in.pixel_col = view ? chain[lpcp_pkg::DIV_CELLS].quo_u[lpcp_pkg::PIX_W-1:0] : '0;
      out_in.pixel_row = view ? chain[lpcp_pkg::DIV_CELLS].quo_v[lpcp_pkg::PIX_W-1:0] : '0;
      out_in.orig_x    = chain[lpcp_pkg::DIV_CELLS].point.point_x;
      out_in.orig_y    = chain[lpcp_pkg::DIV_CELLS].point.point_y;
      out_in.orig_z    = chain[lpcp_pkg::DIV_CELLS].point.point_z;
   end

   // output register, one-cycle strobe per transfer
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain[lpcp_pkg::DIV_CELLS].valid;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(lpcp_pkg::LATENCY) rsp_valid)
      else $error("accepted point gave no result at the expected cycle");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(lpcp_pkg::LATENCY) !rsp_valid)
      else $error("result strobe without an accepted point");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result.in_view) |->
         (rsp_result.pixel_col == '0 && rsp_result.pixel_row == '0))
      else $error("out-of-view result carries nonzero pixel");

   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result.in_view) |->
         (lpcp_pkg::DIM_W'(rsp_result.pixel_col) < dim_w &&
          lpcp_pkg::DIM_W'(rsp_result.pixel_row) < dim_h))
      else $error("in-view pixel outside the image");
`endif
endmodule

FILE: rtl/lpcp_transform.sv
// lpcp_transform: two-stage rigid transform p' = R p + t into the camera frame
// depends on lpcp_pkg
module lpcp_transform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lpcp_pkg::point_type  src_point,
   input  logic [63:0]          row_x,
   input  logic [63:0]          row_y,
   input  logic [63:0]          row_z,
   output lpcp_pkg::xform_type  out_xform
);
   logic signed [39:0] prod_ff [9];
   logic signed [39:0] prod_in [9];
   logic signed [29:0] trans_ff [3];
   logic signed [29:0] trans_in [3];
   logic               valid1_ff;
   lpcp_pkg::point_type point1_ff;
   lpcp_pkg::xform_type xform_ff;
   lpcp_pkg::xform_type xform_in;
   logic [63:0]        rows [3];

   assign rows[0] = row_x;
   assign rows[1] = row_y;
   assign rows[2] = row_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[3*r]   = $signed(rows[r][15:0])  * src_point.point_x;
         prod_in[3*r+1] = $signed(rows[r][31:16]) * src_point.point_y;
         prod_in[3*r+2] = $signed(rows[r][47:32]) * src_point.point_z;
         trans_in[r]    = {$signed(rows[r][63:48]), 14'b0};
      end
   end

   always_comb begin
      xform_in.valid = valid1_ff;
      xform_in.point = point1_ff;
      xform_in.cam_x = lpcp_pkg::CAM_W'(prod_ff[0]) + lpcp_pkg::CAM_W'(prod_ff[1])
                     + lpcp_pkg::CAM_W'(prod_ff[2]) + lpcp_pkg::CAM_W'(trans_ff[0]);
      xform_in.cam_y = lpcp_pkg::CAM_W'(prod_ff[3]) + lpcp_pkg::CAM_W'(prod_ff[4])
                     + lpcp_pkg::CAM_W'(prod_ff[5]) + lpcp_pkg::CAM_W'(trans_ff[1]);
      xform_in.cam_z = lpcp_pkg::CAM_W'(prod_ff[6]) + lpcp_pkg::CAM_W'(prod_ff[7])
                     + lpcp_pkg::CAM_W'(prod_ff[8]) + lpcp_pkg::CAM_W'(trans_ff[2]);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      trans_ff  <= trans_in;
      point1_ff <= src_point;
      if (reset) begin
         valid1_ff      <= 1'b0;
         xform_ff.valid <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         xform_ff  <= xform_in;
      end
   end

   assign out_xform = xform_ff;
endmodule

FILE: rtl/lpcp_project.sv
// lpcp_project: three-stage build of projection numerators, magnitudes and divisor
// depends on lpcp_pkg
module lpcp_project (
   input  logic                 clock,
   input  logic                 reset,
   input  lpcp_pkg::xform_type  in_xform,
   input  logic [15:0]          focal_x,
   input  logic [15:0]          focal_y,
   input  logic [15:0]          center_x,
   input  logic [15:0]          center_y,
   output lpcp_pkg::proj_type   out_proj
);
   // partial products: 0 hi*fx 1 lo*fx 2 hi*fy 3 lo*fy 4 zhi*cx 5 zlo*cx 6 zhi*cy 7 zlo*cy
   logic signed [lpcp_pkg::PROD_W-1:0] pp_ff [8];
   logic signed [lpcp_pkg::PROD_W-1:0] pp_in [8];
   logic                      valid3_ff, pos3_ff;
   logic signed [lpcp_pkg::CAM_W-1:0] cz3_ff;
   lpcp_pkg::point_type       point3_ff;
   logic                      valid4_ff, pos4_ff;
   logic signed [lpcp_pkg::NUM_W-1:0] num_u_ff, num_v_ff, num_u_in, num_v_in;
   logic [lpcp_pkg::DEN_W-1:0] den4_ff;
   lpcp_pkg::point_type       point4_ff;
   lpcp_pkg::proj_type        proj_ff, proj_in;
   logic signed [16:0]        fx_s, fy_s, ccx_s, ccy_s;
   logic signed [21:0]        x_hi, x_lo, y_hi, y_lo, z_hi, z_lo;

   always_comb begin
      fx_s  = {1'b0, focal_x};
      fy_s  = {1'b0, focal_y};
      ccx_s = {1'b0, center_x};
      ccy_s = {1'b0, center_y};
      x_hi  = in_xform.cam_x[lpcp_pkg::CAM_W-1:lpcp_pkg::SPLIT_W];
      x_lo  = {1'b0, in_xform.cam_x[lpcp_pkg::SPLIT_W-1:0]};
      y_hi  = in_xform.cam_y[lpcp_pkg::CAM_W-1:lpcp_pkg::SPLIT_W];
      y_lo  = {1'b0, in_xform.cam_y[lpcp_pkg::SPLIT_W-1:0]};
      z_hi  = in_xform.cam_z[lpcp_pkg::CAM_W-1:lpcp_pkg::SPLIT_W];
      z_lo  = {1'b0, in_xform.cam_z[lpcp_pkg::SPLIT_W-1:0]};
      pp_in[0] = x_hi * fx_s;
      pp_in[1] = x_lo * fx_s;
      pp_in[2] = y_hi * fy_s;
      pp_in[3] = y_lo * fy_s;
      pp_in[4] = z_hi * ccx_s;
      pp_in[5] = z_lo * ccx_s;
      pp_in[6] = z_hi * ccy_s;
      pp_in[7] = z_lo * ccy_s;
   end

   // numerator = coord * focal + center * depth, recombined from halves
   always_comb begin
      num_u_in = (lpcp_pkg::NUM_W'(pp_ff[0]) <<< lpcp_pkg::SPLIT_W)
               + lpcp_pkg::NUM_W'(pp_ff[1])
               + (lpcp_pkg::NUM_W'(pp_ff[4]) <<< lpcp_pkg::SPLIT_W)
               + lpcp_pkg::NUM_W'(pp_ff[5]);
      num_v_in = (lpcp_pkg::NUM_W'(pp_ff[2]) <<< lpcp_pkg::SPLIT_W)
               + lpcp_pkg::NUM_W'(pp_ff[3])
               + (lpcp_pkg::NUM_W'(pp_ff[6]) <<< lpcp_pkg::SPLIT_W)
               + lpcp_pkg::NUM_W'(pp_ff[7]);
   end

   always_comb begin
      proj_in.valid = valid4_ff;
      proj_in.pos   = pos4_ff;
      proj_in.neg_u = num_u_ff[lpcp_pkg::NUM_W-1];
      proj_in.neg_v = num_v_ff[lpcp_pkg::NUM_W-1];
      proj_in.abs_u = num_u_ff[lpcp_pkg::NUM_W-1] ? 0 - num_u_ff : num_u_ff;
      proj_in.abs_v = num_v_ff[lpcp_pkg::NUM_W-1] ? 0 - num_v_ff : num_v_ff;
      proj_in.den   = den4_ff;
      proj_in.point = point4_ff;
   end

   always_ff @(posedge clock) begin
      pp_ff     <= pp_in;
      cz3_ff    <= in_xform.cam_z;
      pos3_ff   <= (in_xform.cam_z > 0);
      point3_ff <= in_xform.point;
      num_u_ff  <= num_u_in;
      num_v_ff  <= num_v_in;
      den4_ff   <= {cz3_ff[lpcp_pkg::DEN_W-5:0], 4'b0};
      pos4_ff   <= pos3_ff;
      point4_ff <= point3_ff;
      if (reset) begin
         valid3_ff     <= 1'b0;
         valid4_ff     <= 1'b0;
         proj_ff.valid <= 1'b0;
      end else begin
         valid3_ff <= in_xform.valid;
         valid4_ff <= valid3_ff;
         proj_ff   <= proj_in;
      end
   end

   assign out_proj = proj_ff;
endmodule

FILE: rtl/lpcp_div_cell.sv
// lpcp_div_cell: one restoring division step for both pixel axes, registered
// depends on lpcp_pkg
module lpcp_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  lpcp_pkg::div_type  in_div,
   output lpcp_pkg::div_type  out_div
);
   lpcp_pkg::div_type         div_ff, div_in;
   logic [lpcp_pkg::NUM_W-1:0] den_sh, diff_u, diff_v;
   logic                      ge_u, ge_v;

   always_comb begin
      den_sh = lpcp_pkg::NUM_W'({in_div.den, (lpcp_pkg::DIV_CELLS - 1)'(0)});
      ge_u   = (in_div.rem_u >= den_sh);
      ge_v   = (in_div.rem_v >= den_sh);
      diff_u = ge_u ? in_div.rem_u - den_sh : in_div.rem_u;
      diff_v = ge_v ? in_div.rem_v - den_sh : in_div.rem_v;
      div_in       = in_div;
      div_in.rem_u = diff_u << 1;
      div_in.rem_v = diff_v << 1;
      div_in.quo_u = {in_div.quo_u[lpcp_pkg::DIV_CELLS-2:0], ge_u};
      div_in.quo_v = {in_div.quo_v[lpcp_pkg::DIV_CELLS-2:0], ge_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else begin
         div_ff <= div_in;
      end
   end

   assign out_div = div_ff;
endmodule
